### hdl/sle_pkg.sv
// Shared types and constants for the serial line editor.
package sle_pkg;

   localparam int LINE_DEPTH_DEFAULT = 32;

   // Result kinds
   localparam logic [1:0] KIND_ECHO   = 2'd0;
   localparam logic [1:0] KIND_ERASE  = 2'd1;
   localparam logic [1:0] KIND_LINE   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_FRAMING = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN = 2'd2;
   localparam logic [1:0] STATUS_INTR    = 2'd3;

   // Character codes
   localparam logic [7:0] CHAR_BEL    = 8'h07;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TILDE  = 8'h7E;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;
   localparam logic [7:0] CHAR_HI_PRT = 8'hA0;
   localparam logic [7:0] CHAR_CTRL_C = 8'h03;
   localparam logic [7:0] CHAR_CTRL_R = 8'h12;
   localparam logic [7:0] CHAR_CTRL_U = 8'h15;
   localparam logic [7:0] CHAR_CTRL_W = 8'h17;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_NL_LF,
      S_LINE,
      S_REPRINT,
      S_KILL,
      S_WORD_CHK,
      S_WORD_ERASE
   } state_type;

endpackage

### hdl/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/serial_line_editor.sv
// Serial line editor top level: decoder, sequencer and line store.
//
// Takes one received byte per item and answers with zero to LINE_DEPTH+2
// result items, the final one flagged by rsp_last. An item is latched when
// accepted and then decoded; after that each result is issued as soon as
// the result side can take it, that is while rsp_valid is low or rsp_ready
// is high. The stored line is walked through the single read port of the
// line RAM, one byte per cycle while rsp_ready stays high, with the address
// taken from the next-state index so the registered read data is ready when
// the byte is used. The next item is taken only once the current one has
// issued its last result. The line RAM needs no clearing after reset: only bytes below the fill count are ever used.
module serial_line_editor #(
   parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_framing_error,
   input  logic       req_overrun_error,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   localparam int AW = $clog2(LINE_DEPTH);

   sle_pkg::state_type state_ff, state_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    byte_ff;
   logic          fe_ff, ov_ff;

   logic          rsp_valid_ff;
   logic [1:0]    kind_ff, status_ff;
   logic [7:0]    value_ff;
   logic          last_ff;

   logic          out_free;
   logic          emit;
   logic [1:0]    e_kind, e_status;
   logic [7:0]    e_value;
   logic          e_last;

   logic          wr_en;
   logic [7:0]    rd_data;
   logic [7:0]    c;
   logic          printable;

   sle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (c),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // CR folds to LF, TAB to space
   always_comb begin
      c = byte_ff;
      if (byte_ff == sle_pkg::CHAR_CR) begin
         c = sle_pkg::CHAR_LF;
      end else if (byte_ff == sle_pkg::CHAR_TAB) begin
         c = sle_pkg::CHAR_SPACE;
      end
   end

   assign printable = (c >= sle_pkg::CHAR_SPACE && c <= sle_pkg::CHAR_TILDE) ||
                      (c >= sle_pkg::CHAR_HI_PRT);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      emit      = 1'b0;
      e_kind    = sle_pkg::KIND_ECHO;
      e_value   = 8'h00;
      e_status  = sle_pkg::STATUS_NONE;
      e_last    = 1'b0;
      wr_en     = 1'b0;
      req_ready = 1'b0;

      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = sle_pkg::S_DECODE;
            end
         end

         sle_pkg::S_DECODE: begin
            if (out_free) begin
               state_in = sle_pkg::S_IDLE;
               if (fe_ff || ov_ff) begin
                  emit     = 1'b1;
                  e_kind   = sle_pkg::KIND_STATUS;
                  e_status = fe_ff ? sle_pkg::STATUS_FRAMING : sle_pkg::STATUS_OVERRUN;
                  e_last   = 1'b1;
                  fill_in  = '0;
               end else if (c == sle_pkg::CHAR_LF) begin
                  emit     = 1'b1;
                  e_value  = sle_pkg::CHAR_CR;
                  idx_in   = '0;
                  state_in = sle_pkg::S_NL_LF;
               end else if (printable) begin
                  emit   = 1'b1;
                  e_last = 1'b1;
                  if (fill_ff >= AW'(LINE_DEPTH - 1)) begin
                     e_value = sle_pkg::CHAR_BEL;
                  end else begin
                     wr_en   = 1'b1;
                     fill_in = fill_ff + AW'(1);
                     e_value = c;
                  end
               end else begin
                  unique case (c) inside
                     sle_pkg::CHAR_CTRL_C: begin
                        emit     = 1'b1;
                        e_kind   = sle_pkg::KIND_STATUS;
                        e_status = sle_pkg::STATUS_INTR;
                        e_last   = 1'b1;
                        fill_in  = '0;
                     end
                     sle_pkg::CHAR_BS, sle_pkg::CHAR_DEL: begin
                        if (fill_ff != '0) begin
                           emit    = 1'b1;
                           e_kind  = sle_pkg::KIND_ERASE;
                           e_last  = 1'b1;
                           fill_in = fill_ff - AW'(1);
                        end
                     end
                     sle_pkg::CHAR_CTRL_R: begin
                        emit    = 1'b1;
                        e_value = sle_pkg::CHAR_CR;
                        e_last  = (fill_ff == '0);
                        idx_in  = '0;
                        if (fill_ff != '0) begin
                           state_in = sle_pkg::S_REPRINT;
                        end
                     end
                     sle_pkg::CHAR_CTRL_U: begin
                        if (fill_ff != '0) begin
                           state_in = sle_pkg::S_KILL;
                        end
                     end
                     sle_pkg::CHAR_CTRL_W: begin
                        if (fill_ff != '0) begin
                           idx_in   = fill_ff - AW'(1);
                           state_in = sle_pkg::S_WORD_CHK;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         sle_pkg::S_NL_LF: begin
            if (out_free) begin
               emit     = 1'b1;
               e_value  = sle_pkg::CHAR_LF;
               state_in = sle_pkg::S_LINE;
            end
         end

         // rd_data holds the byte at idx_ff
         sle_pkg::S_LINE: begin
            if (out_free) begin
               emit   = 1'b1;
               e_kind = sle_pkg::KIND_LINE;
               if (idx_ff == fill_ff) begin
                  e_value  = sle_pkg::CHAR_LF;
                  e_last   = 1'b1;
                  fill_in  = '0;
                  state_in = sle_pkg::S_IDLE;
               end else begin
                  e_value = rd_data;
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end

         sle_pkg::S_REPRINT: begin
            if (out_free) begin
               emit    = 1'b1;
               e_value = rd_data;
               e_last  = (idx_ff + AW'(1) == fill_ff);
               if (e_last) begin
                  state_in = sle_pkg::S_IDLE;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end

         sle_pkg::S_KILL: begin
            if (out_free) begin
               emit    = 1'b1;
               e_kind  = sle_pkg::KIND_ERASE;
               e_last  = (fill_ff == AW'(1));
               fill_in = fill_ff - AW'(1);
               if (e_last) begin
                  state_in = sle_pkg::S_IDLE;
               end
            end
         end

         // rd_data is the byte just before the cursor
         sle_pkg::S_WORD_CHK: begin
            if (rd_data == sle_pkg::CHAR_SPACE) begin
               state_in = sle_pkg::S_IDLE;
            end else begin
               state_in = sle_pkg::S_WORD_ERASE;
               if (fill_ff != AW'(1)) begin
                  idx_in = idx_ff - AW'(1);
               end
            end
         end

         // erase of the byte at fill-1 is pending; rd_data looks one byte ahead
         sle_pkg::S_WORD_ERASE: begin
            if (out_free) begin
               emit    = 1'b1;
               e_kind  = sle_pkg::KIND_ERASE;
               e_last  = (fill_ff == AW'(1)) || (rd_data == sle_pkg::CHAR_SPACE);
               fill_in = fill_ff - AW'(1);
               if (e_last) begin
                  state_in = sle_pkg::S_IDLE;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end
         end

         default: begin
            state_in = sle_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::S_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
         fe_ff   <= req_framing_error;
         ov_ff   <= req_overrun_error;
      end
      if (emit) begin
         kind_ff   <= e_kind;
         value_ff  <= e_value;
         status_ff <= e_status;
         last_ff   <= e_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule
